@@ design/svs_pkg.sv @@
// Shared types and constants for the stepper valve sequencer.
// No dependencies; every other design file imports this package.
`default_nettype none

package svs_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_OPEN  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_QUERY = 2'd3
	} cmd_op_t;

	typedef enum logic [1:0] {
		REQ_NONE  = 2'd0,
		REQ_OPEN  = 2'd1,
		REQ_CLOSE = 2'd2
	} req_t;

	typedef enum logic {
		SEQ_IDLE = 1'b0,
		SEQ_TICK = 1'b1
	} seq_state_t;

	localparam logic [2:0] POS_UNKNOWN = 3'd0;
	localparam logic [2:0] POS_OPENED  = 3'd1;
	localparam logic [2:0] POS_CLOSED  = 3'd2;
	localparam logic [2:0] POS_OPENING = 3'd3;
	localparam logic [2:0] POS_CLOSING = 3'd4;

	localparam logic KIND_DRIVE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	localparam logic [1:0] REG_TRAVEL = 2'd0;
	localparam logic [1:0] REG_PERIOD = 2'd1;
	localparam logic [1:0] REG_START  = 2'd2;

	localparam logic [13:0] TRAVEL_RESET = 14'd1250;
	localparam logic [7:0]  PERIOD_RESET = 8'd8;
	localparam logic [1:0]  START_RESET  = 2'd0;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic [1:0] command;
		logic [1:0] valve;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] valve_id;
		logic       kind;
		logic       coils_on;
		logic [2:0] phase;
		logic       busy_res;
		logic [2:0] position;
		logic       last;
	} res_item_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [1:0] valve;
	} q_entry_t;

	typedef struct packed {
		logic [13:0] travel;
		logic [7:0]  period;
		logic        pos_load;
		logic [2:0]  pos_value;
	} cfg_t;

endpackage

`default_nettype wire

@@ design/stepper_valve_sequencer.sv @@
// Stepper valve sequencer, half-step drive of up to NUM_VALVES valves. Commands
// enter a two-item queue; open, close and busy query are taken straight from the
// queue while idle, and a tick visits one valve a cycle, unless res_stall holds it,
// through the single shared valve-update path. An item that produces a result
// also waits out every cycle in which res_stall holds the previous result in the
// output register. Depends on svs_pkg, svs_front, svs_queue and svs_back.
`default_nettype none

module stepper_valve_sequencer #(
	parameter int NUM_VALVES = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire svs_pkg::cmd_item_t cmd,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output svs_pkg::res_item_t      res
);
	import svs_pkg::*;

	logic     push, q_full, q_pop, q_valid;
	q_entry_t push_data, q_data;
	cfg_t     cfg;

	svs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full),
		.cfg       (cfg)
	);

	svs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.data      (q_data)
	);

	svs_back #(
		.NUM_VALVES (NUM_VALVES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire

@@ design/svs_front.sv @@
// Front part: configuration registers on the APB port, command intake and decode.
// Depends on svs_pkg; feeds svs_queue and hands configuration to svs_back.
`default_nettype none

module svs_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire svs_pkg::cmd_item_t cmd,
	output logic                    push,
	output svs_pkg::q_entry_t       push_data,
	input  wire logic               q_full,
	output svs_pkg::cfg_t           cfg
);
	import svs_pkg::*;

	logic [13:0] travel_q;
	logic [7:0]  period_q;
	logic [1:0]  start_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_q <= TRAVEL_RESET;
			period_q <= PERIOD_RESET;
			start_q  <= START_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TRAVEL: travel_q <= pwdata[13:0];
				REG_PERIOD: period_q <= pwdata[7:0];
				REG_START:  start_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TRAVEL: prdata = {18'd0, travel_q};
			REG_PERIOD: prdata = {24'd0, period_q};
			REG_START:  prdata = {30'd0, start_q};
			default:    prdata = 32'd0;
		endcase
	end

	// start position code 3 loads as unknown
	always_comb begin
		cfg.travel    = travel_q;
		cfg.period    = period_q;
		cfg.pos_load  = wr_en && (reg_idx == REG_START);
		cfg.pos_value = (pwdata[1:0] == 2'd3) ? POS_UNKNOWN : {1'b0, pwdata[1:0]};
	end

	assign cmd_stall       = q_full;
	assign push            = cmd_valid && !q_full;
	assign push_data.op    = cmd_op_t'(cmd.command);
	assign push_data.valve = cmd.valve;

endmodule

`default_nettype wire

@@ design/svs_queue.sv @@
// Short command queue between the front and back parts.
// Depends on svs_pkg for the entry type and depth.
`default_nettype none

module svs_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire svs_pkg::q_entry_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   valid,
	output svs_pkg::q_entry_t      data
);
	import svs_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	q_entry_t        mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full  = (count_q == CW'(QDEPTH));
	assign valid = (count_q != '0);
	assign data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ design/svs_back.sv @@
// Back part: per-valve state, the tick sequencer that visits one valve a cycle
// unless a result stall holds it, and the result register. Depends on svs_pkg; fed by svs_queue.
`default_nettype none

module svs_back #(
	parameter int NUM_VALVES = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire svs_pkg::cfg_t     cfg,
	input  wire logic              q_valid,
	input  wire svs_pkg::q_entry_t q_data,
	output logic                   q_pop,
	output logic                   res_valid,
	input  wire logic              res_stall,
	output svs_pkg::res_item_t     res
);
	import svs_pkg::*;

	localparam int VW = (NUM_VALVES > 1) ? $clog2(NUM_VALVES) : 1;

	logic [2:0]         pos_q   [NUM_VALVES];
	req_t               req_q   [NUM_VALVES];
	logic signed [15:0] steps_q [NUM_VALVES];
	logic [2:0]         ph_q    [NUM_VALVES];
	logic [7:0]         cd_q    [NUM_VALVES];

	seq_state_t state_q, state_d;
	logic [VW-1:0] v_q;
	logic          res_valid_q;
	res_item_t     res_q, res_d;

	logic [NUM_VALVES-1:0] moving, exp_vec, sel_vec, higher_vec;
	logic [VW+1:0] q_wide, v_wide;
	logic [VW-1:0] idx;
	logic          q_in_range, slot_free, load_res, do_valve, wr_req, v_last;

	logic [2:0]         pos_r, pos_a, pos_n, ph_r, ph_n, ph_out;
	req_t               req_r, req_a;
	logic signed [15:0] st_r, st_a, st_n;
	logic signed [16:0] sum_open, sum_close;
	logic [7:0]         cd_r, cd_n;
	logic               others, exp_cur, coils, later_exp;

	assign q_wide     = (VW+2)'(q_data.valve);
	assign v_wide     = (VW+2)'(v_q);
	assign q_in_range = (q_wide < (VW+2)'(NUM_VALVES));
	assign idx        = (state_q == SEQ_TICK) ? v_q : q_wide[VW-1:0];
	assign slot_free  = !res_valid_q || !res_stall;
	assign v_last     = (v_q == VW'(NUM_VALVES - 1));

	always_comb begin
		for (int k = 0; k < NUM_VALVES; k++) begin
			moving[k]     = (pos_q[k] == POS_OPENING) || (pos_q[k] == POS_CLOSING);
			exp_vec[k]    = (cd_q[k] <= 8'd1);
			sel_vec[k]    = (idx == VW'(k));
			higher_vec[k] = (VW'(k) > idx);
		end
	end

	assign pos_r = pos_q[idx];
	assign req_r = req_q[idx];
	assign st_r  = steps_q[idx];
	assign ph_r  = ph_q[idx];
	assign cd_r  = cd_q[idx];

	assign others    = |(moving & ~sel_vec);
	assign later_exp = |(exp_vec & higher_vec);
	assign exp_cur   = (cd_r <= 8'd1);
	assign sum_open  = {st_r[15], st_r} + $signed({3'b000, cfg.travel});
	assign sum_close = {st_r[15], st_r} - $signed({3'b000, cfg.travel});

	// request take-up, then countdown and step for the visited valve
	always_comb begin
		pos_a = pos_r;
		req_a = req_r;
		st_a  = st_r;
		if (!others) begin
			req_a = REQ_NONE;
			case (req_r)
				REQ_OPEN: begin
					if (pos_r == POS_CLOSED) begin
						pos_a = POS_OPENING;
						st_a  = $signed({2'b00, cfg.travel});
					end else if (pos_r == POS_CLOSING) begin
						pos_a = POS_OPENING;
						st_a  = (sum_open[16] != sum_open[15])
							? (sum_open[16] ? 16'sh8000 : 16'sh7fff) : sum_open[15:0];
					end
				end
				REQ_CLOSE: begin
					if (pos_r == POS_OPENED) begin
						pos_a = POS_CLOSING;
						st_a  = 16'(-$signed({2'b00, cfg.travel}));
					end else if (pos_r == POS_OPENING) begin
						pos_a = POS_CLOSING;
						st_a  = (sum_close[16] != sum_close[15])
							? (sum_close[16] ? 16'sh8000 : 16'sh7fff) : sum_close[15:0];
					end
				end
				default: ;
			endcase
		end
		pos_n  = pos_a;
		st_n   = st_a;
		ph_n   = ph_r;
		ph_out = 3'd0;
		coils  = 1'b0;
		cd_n   = (cd_r != 8'd0) ? cd_r - 8'd1 : 8'd0;
		if (exp_cur) begin
			cd_n = cfg.period;
			if (st_a == 16'sd0) begin
				if (pos_a == POS_OPENING) begin
					pos_n = POS_OPENED;
				end else if (pos_a == POS_CLOSING) begin
					pos_n = POS_CLOSED;
				end
			end else begin
				coils  = 1'b1;
				ph_out = ph_r;
				if (!st_a[15]) begin
					st_n = st_a - 16'sd1;
					ph_n = ph_r + 3'd1;
				end else begin
					st_n = st_a + 16'sd1;
					ph_n = ph_r - 3'd1;
				end
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_res = 1'b0;
		do_valve = 1'b0;
		wr_req   = 1'b0;
		res_d    = res_q;
		case (state_q)
			SEQ_IDLE: begin
				if (q_valid) begin
					case (q_data.op)
						CMD_TICK: begin
							q_pop   = 1'b1;
							state_d = SEQ_TICK;
						end
						CMD_OPEN, CMD_CLOSE: begin
							q_pop  = 1'b1;
							wr_req = q_in_range;
						end
						CMD_QUERY: begin
							if (slot_free) begin
								q_pop          = 1'b1;
								load_res       = 1'b1;
								res_d.valve_id = q_data.valve;
								res_d.kind     = KIND_QUERY;
								res_d.coils_on = 1'b0;
								res_d.phase    = 3'd0;
								res_d.busy_res = q_in_range &&
									((pos_r == POS_OPENING) || (pos_r == POS_CLOSING) ||
									(req_r != REQ_NONE));
								res_d.position = q_in_range ? pos_r : POS_UNKNOWN;
								res_d.last     = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			SEQ_TICK: begin
				if (!exp_cur || slot_free) begin
					do_valve       = 1'b1;
					load_res       = exp_cur;
					res_d.valve_id = v_wide[1:0];
					res_d.kind     = KIND_DRIVE;
					res_d.coils_on = coils;
					res_d.phase    = ph_out;
					res_d.busy_res = (pos_n == POS_OPENING) || (pos_n == POS_CLOSING) ||
						(req_a != REQ_NONE);
					res_d.position = pos_n;
					res_d.last     = !later_exp;
					if (v_last) begin
						state_d = SEQ_IDLE;
					end
				end
			end
			default: state_d = SEQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SEQ_IDLE;
			v_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q != SEQ_TICK || (do_valve && v_last)) begin
				v_q <= '0;
			end else if (do_valve) begin
				v_q <= v_q + 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_VALVES; k++) begin
				pos_q[k]   <= POS_UNKNOWN;
				req_q[k]   <= REQ_CLOSE;
				steps_q[k] <= 16'sd0;
				ph_q[k]    <= 3'd0;
				cd_q[k]    <= PERIOD_RESET;
			end
		end else begin
			for (int k = 0; k < NUM_VALVES; k++) begin
				if (cfg.pos_load) begin
					pos_q[k] <= cfg.pos_value;
				end else if (do_valve && sel_vec[k]) begin
					pos_q[k] <= pos_n;
				end
				if (do_valve && sel_vec[k]) begin
					req_q[k]   <= req_a;
					steps_q[k] <= st_n;
					ph_q[k]    <= ph_n;
					cd_q[k]    <= cd_n;
				end else if (wr_req && sel_vec[k]) begin
					req_q[k] <= (q_data.op == CMD_OPEN) ? REQ_OPEN : REQ_CLOSE;
				end
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a request only starts travel when no other valve moves
	a_one_mover: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(moving) <= 1)
		else $error("more than one valve in motion");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_res && res_valid_q |-> !res_stall)
		else $error("result register overwritten while stalled");

	a_valve_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_TICK |-> v_q <= VW'(NUM_VALVES - 1))
		else $error("tick visit beyond last valve");

	a_tick_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SEQ_TICK && do_valve && v_last |=> state_q == SEQ_IDLE && v_q == '0)
		else $error("tick did not end after last valve");

endmodule

`default_nettype wire
